/* sv/arw_pkg.sv */
// Shared types, constants and helper functions for the anti-replay window block.
`default_nettype none

package arw_pkg;

    localparam int unsigned WIN_BITS = 64;
    localparam int unsigned SEQ_W    = 64;
    localparam int unsigned LIMIT_W  = 32;
    localparam int unsigned CNT_W    = 7;
    localparam int unsigned IDX_W    = 6;

    typedef logic signed [SEQ_W-1:0] seq_t;
    typedef logic [WIN_BITS-1:0]     mask_t;
    typedef logic [LIMIT_W-1:0]      limit_t;
    typedef logic [CNT_W-1:0]        cnt_t;
    typedef logic [IDX_W-1:0]        idx_t;

    localparam limit_t LIMIT_RESET = 32'd1048576;

    localparam logic OP_INIT   = 1'b0;
    localparam logic OP_VERIFY = 1'b1;

    function automatic cnt_t count_ones(input mask_t v);
        cnt_t n;
        n = '0;
        for (int i = 0; i < WIN_BITS; i++)
        begin
            n = n + cnt_t'(v[i]);
        end
        return n;
    endfunction

endpackage

`default_nettype wire

/* sv/arw_if.sv */
// Handshake channel interfaces for requests, results and the limit register write.
`default_nettype none

interface arw_req_if;
    logic              valid;
    logic              ready;
    logic              op;
    arw_pkg::seq_t     seq;

    modport source (output valid, output op, output seq, input ready);
    modport sink   (input valid, input op, input seq, output ready);
endinterface

interface arw_rsp_if;
    logic              valid;
    logic              ready;
    logic              accepted;
    arw_pkg::seq_t     window_start;
    arw_pkg::cnt_t     received_count;

    modport source (output valid, output accepted, output window_start,
                    output received_count, input ready);
    modport sink   (input valid, input accepted, input window_start,
                    input received_count, output ready);
endinterface

interface arw_cfg_if;
    logic              valid;
    logic              ready;
    arw_pkg::limit_t   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* sv/anti_replay_window.sv */
// Top level: sliding 64-entry anti-replay window check.
//
//   channel  dir  fields                                   handshake
//   req      in   op, seq                                  valid/ready
//   rsp      out  accepted, window_start, received_count   valid/ready
//   cfg      in   data (forward_limit)                     valid/ready
//
// One request per cycle sustained while rsp is ready; a result is valid once its
// request has passed the input register and then the result register (window
// update and popcount). The window state is updated in that same step, so
// consecutive requests see each other.
// Reset clears the window base, the seen mask and both valid flags; forward_limit
// returns to 1048576. A stalled rsp holds back the input only once both are full.
`default_nettype none

module anti_replay_window (
    input  wire logic    clk,
    input  wire logic    rst_n,
    arw_req_if.sink      req,
    arw_rsp_if.source    rsp,
    arw_cfg_if.sink      cfg
);

    // pipeline control
    logic s0_valid_reg, s0_valid_next;
    logic s1_valid_reg, s1_valid_next;
    logic s1_ready, s0_ready;
    logic req_fire, s1_take;

    // stage payloads
    logic            s0_op_reg;
    arw_pkg::seq_t   s0_seq_reg;
    logic            s1_acc_reg, s1_acc_next;
    arw_pkg::mask_t  s1_base_reg;
    arw_pkg::cnt_t   s1_cnt_reg, s1_cnt_next;

    // window state
    arw_pkg::mask_t  base_reg, base_next;
    arw_pkg::mask_t  mask_reg, mask_next;
    arw_pkg::limit_t limit_reg;

    // verify datapath
    arw_pkg::mask_t  diff;
    arw_pkg::limit_t delta;
    arw_pkg::limit_t shift;
    arw_pkg::mask_t  shifted;
    arw_pkg::mask_t  adv_base;
    logic [arw_pkg::CNT_W-1:0] back;
    arw_pkg::idx_t   bit_idx;
    logic            in_range, far, hit, ok;

    assign s1_ready  = !s1_valid_reg || rsp.ready;
    assign s0_ready  = !s0_valid_reg || s1_ready;

    assign req_fire = req.valid && s0_ready;
    assign s1_take  = s0_valid_reg && s1_ready;

    assign req.ready = s0_ready;
    assign cfg.ready = 1'b1;

    always_comb
    begin
        diff     = arw_pkg::mask_t'(s0_seq_reg) - base_reg;
        delta    = diff[arw_pkg::LIMIT_W-1:0];
        in_range = (diff[arw_pkg::WIN_BITS-1:arw_pkg::LIMIT_W] == '0) && (delta != '0)
                   && (delta < limit_reg);
        far      = delta > arw_pkg::limit_t'(arw_pkg::WIN_BITS);
        shift    = delta - arw_pkg::limit_t'(arw_pkg::WIN_BITS);
        adv_base = base_reg + arw_pkg::mask_t'(shift);
        if (!far)
        begin
            shifted = mask_reg;
        end
        else if (shift[arw_pkg::LIMIT_W-1:arw_pkg::IDX_W] != '0)
        begin
            shifted = '0;
        end
        else
        begin
            shifted = mask_reg << shift[arw_pkg::IDX_W-1:0];
        end
        back    = arw_pkg::cnt_t'(arw_pkg::WIN_BITS) - delta[arw_pkg::CNT_W-1:0];
        bit_idx = far ? '0 : back[arw_pkg::IDX_W-1:0];
        hit     = shifted[bit_idx];
        ok      = in_range && !hit;

        base_next   = base_reg;
        mask_next   = mask_reg;
        s1_acc_next = 1'b0;
        if (s0_op_reg == arw_pkg::OP_INIT)
        begin
            base_next = arw_pkg::mask_t'(s0_seq_reg);
            mask_next = '0;
        end
        else if (ok)
        begin
            base_next   = far ? adv_base : base_reg;
            mask_next   = shifted | (arw_pkg::mask_t'(1) << bit_idx);
            s1_acc_next = 1'b1;
        end
        s1_cnt_next = arw_pkg::count_ones(mask_next);
    end

    always_comb
    begin
        s0_valid_next = req_fire ? 1'b1 : (s1_take ? 1'b0 : s0_valid_reg);
        s1_valid_next = s1_take ? 1'b1 : ((s1_valid_reg && rsp.ready) ? 1'b0
                                                                     : s1_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            base_reg     <= '0;
            mask_reg     <= '0;
            limit_reg    <= arw_pkg::LIMIT_RESET;
        end
        else
        begin
            s0_valid_reg <= s0_valid_next;
            s1_valid_reg <= s1_valid_next;
            if (s1_take)
            begin
                base_reg <= base_next;
                mask_reg <= mask_next;
            end
            if (cfg.valid)
            begin
                limit_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s0_op_reg  <= req.op;
            s0_seq_reg <= req.seq;
        end
        if (s1_take)
        begin
            s1_acc_reg  <= s1_acc_next;
            s1_base_reg <= base_next;
            s1_cnt_reg  <= s1_cnt_next;
        end
    end

    assign rsp.valid          = s1_valid_reg;
    assign rsp.accepted       = s1_acc_reg;
    assign rsp.window_start   = arw_pkg::seq_t'(s1_base_reg);
    assign rsp.received_count = s1_cnt_reg;

`ifndef SYNTHESIS
    a_acc_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.accepted |-> rsp.received_count != '0)
        else $error("accepted result with empty mask");

    a_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_take && s0_op_reg == arw_pkg::OP_VERIFY && !ok
        |=> $stable(base_reg) && $stable(mask_reg))
        else $error("rejected request changed window state");

    a_init_clears: assert property (@(posedge clk) disable iff (!rst_n)
        s1_take && s0_op_reg == arw_pkg::OP_INIT |=> mask_reg == '0)
        else $error("init did not clear mask");
`endif

endmodule

`default_nettype wire
